@@ hw/rtl/dns_wire_name_to_text_top_defines.svh @@
// ----------------------------------------------------------------------------
// DNS name to text: assertion macros
// Shared macros for the checker that watches the top level's ports.
// ----------------------------------------------------------------------------
`ifndef DNS_WIRE_NAME_TO_TEXT_TOP_DEFINES_SVH
`define DNS_WIRE_NAME_TO_TEXT_TOP_DEFINES_SVH

// Check a same-cycle implication on the rising clock edge, off during reset.
`define DWNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on the rising clock edge, off during reset.
`define DWNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dwnt_pkg.sv @@
// ----------------------------------------------------------------------------
// DNS name to text: shared package
// Types, character constants and helper functions used by the front end,
// the command queue and the character generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dwnt_pkg;

  // Width fixed by the length limit register and the consumed-bytes field
  localparam int unsigned LIMIT_W     = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd490;

  // Escape form is four characters; the check leaves room for one more
  localparam int unsigned ESC_CHARS   = 4;
  localparam int unsigned ESC_MARGIN  = 5;

  // Command queue depth between front end and generator
  localparam int unsigned QUEUE_DEPTH = 4;

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_LABEL  = 2'd2
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Leading part of the results of one item
  typedef enum logic [1:0] {
    BODY_NONE  = 2'd0,
    BODY_PLAIN = 2'd1,
    BODY_ESC   = 2'd2,
    BODY_DONE  = 2'd3
  } body_e;

  // Trailing result of one item
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_DOT  = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_e;

  // Command passed from the front end to the generator
  typedef struct packed {
    body_e              body;
    tail_e              tail;
    logic [7:0]         data;
    logic [LIMIT_W-1:0] consumed;
  } cmd_t;

  // Lower-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (CH_ZERO + {4'd0, v}) : (CH_LA + {4'd0, v} - 8'd10);
  endfunction

  // Letter, digit, dash or underscore
  function automatic logic plain_char(input logic [7:0] b);
    plain_char = (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LA && b <= CH_LZ) ||
                 (b >= CH_UA && b <= CH_UZ) || b == CH_DASH || b == CH_UNDER;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dns_wire_name_to_text_top.sv @@
// An accepted item goes into the command queue, then its results into the output register.
// One result per cycle unless stalled; an item has 0 to 5 results (escape + dot is 5).
// The four-entry command queue lets input items enter every cycle while it has room.
// Reset (rst_ni low, asynchronous): parser idle, counters zero, queue empty, limit 490.
// ----------------------------------------------------------------------------
// DNS name to text: top level
// Converts wire-format DNS name bytes into printable text characters with
// terminator and overflow results.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_wire_name_to_text_top import dwnt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: length_limit
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  // Input stream
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,  // [7:0] name_byte
  input  wire logic               s_axis_tuser_i,  // [0] start_of_name
  // Output stream
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [23:0]             m_axis_tdata_o,  // [7:0] text_char, [17:8] bytes_consumed
  output logic [1:0]              m_axis_tuser_o,  // [1:0] status
  output logic                    m_axis_tlast_o   // last
);

  logic       full, push, pop, head_valid, in_accept;
  cmd_t       push_cmd, head_cmd;
  logic [7:0] text_char;
  logic [LIMIT_W-1:0] consumed;

  assign s_axis_tready_o = !full;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Parse and classify
  dwnt_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_accept),
    .name_byte_i (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Buffer commands
  dwnt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .valid_o    (head_valid)
  );

  // Generate characters
  dwnt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_cmd_i   (head_cmd),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .text_char_o  (text_char),
    .status_o     (m_axis_tuser_o),
    .consumed_o   (consumed),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, consumed, text_char};

endmodule

`default_nettype wire

@@ hw/rtl/dwnt_front.sv @@
// ----------------------------------------------------------------------------
// DNS name to text: front end
// Parses length and content bytes, runs the limit checks and turns each
// content byte or name end into one command for the character generator.
// ----------------------------------------------------------------------------
`default_nettype none

module dwnt_front import dwnt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic               accept_i,
  input  wire logic [7:0]         name_byte_i,
  input  wire logic               start_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned EW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

  logic [LIMIT_W-1:0] lim_q;
  phase_e             phase_q, phase_d, ph_eff;
  logic [6:0]         lr_q, lr_d;
  logic [CW-1:0]      idx_q, idx_d, oc_q, oc_d;
  logic [CW-1:0]      idx_len, oc_cur, oc1;
  logic [EW-1:0]      lim_x, oc5_x, idx_len_x;

  // Saturating counter add
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic [2:0] by);
    logic [CW:0] s;
    s = {1'b0, v} + {{(CW-2){1'b0}}, by};
    sat_inc = s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // Counter at or above the limit
  function automatic logic at_lim(input logic [CW-1:0] v, input logic [EW-1:0] lim);
    at_lim = {{(EW-CW){1'b0}}, v} >= lim;
  endfunction

  assign lim_x     = {{(EW-LIMIT_W){1'b0}}, lim_q};
  assign oc5_x     = {{(EW-CW){1'b0}}, oc_q} + EW'(ESC_MARGIN);
  assign ph_eff    = start_i ? PH_LENGTH : phase_q;
  assign idx_len   = start_i ? '0 : sat_inc(idx_q, 3'd1);
  assign oc_cur    = start_i ? '0 : oc_q;
  assign idx_len_x = {{(EW-CW){1'b0}}, idx_len};

  // Parse one item and build its command
  always_comb begin
    phase_d      = phase_q;
    lr_d         = lr_q;
    idx_d        = idx_q;
    oc_d         = oc_q;
    oc1          = oc_q;
    push_o       = 1'b0;
    cmd_o.body     = BODY_NONE;
    cmd_o.tail     = TAIL_NONE;
    cmd_o.data     = name_byte_i;
    cmd_o.consumed = '0;
    if (accept_i) begin
      if (start_i) begin
        idx_d = '0;
        oc_d  = '0;
        lr_d  = '0;
      end
      case (ph_eff)
        PH_LENGTH: begin
          idx_d = idx_len;
          if (name_byte_i == 8'd0 || name_byte_i[7]) begin
            // End of name
            phase_d = PH_IDLE;
            push_o  = 1'b1;
            if (at_lim(oc_cur, lim_x)) begin
              cmd_o.tail = TAIL_ERR;
            end else begin
              cmd_o.body     = BODY_DONE;
              cmd_o.consumed = idx_len_x[LIMIT_W-1:0];
            end
          end else begin
            lr_d    = name_byte_i[6:0];
            phase_d = PH_LABEL;
          end
        end
        PH_LABEL: begin
          push_o = 1'b1;
          if (at_lim(idx_q, lim_x) || at_lim(oc_q, lim_x)) begin
            cmd_o.tail = TAIL_ERR;
            phase_d    = PH_IDLE;
          end else begin
            idx_d = sat_inc(idx_q, 3'd1);
            if (plain_char(name_byte_i)) begin
              cmd_o.body = BODY_PLAIN;
              oc1        = sat_inc(oc_q, 3'd1);
            end else if (oc5_x >= lim_x) begin
              cmd_o.tail = TAIL_ERR;
              phase_d    = PH_IDLE;
            end else begin
              cmd_o.body = BODY_ESC;
              oc1        = sat_inc(oc_q, 3'(ESC_CHARS));
            end
            if (cmd_o.tail == TAIL_NONE) begin
              lr_d = lr_q - 7'd1;
              oc_d = oc1;
              // Close the label with a dot
              if (lr_q == 7'd1) begin
                if (at_lim(oc1, lim_x)) begin
                  cmd_o.tail = TAIL_ERR;
                  phase_d    = PH_IDLE;
                end else begin
                  cmd_o.tail = TAIL_DOT;
                  oc_d       = sat_inc(oc1, 3'd1);
                  phase_d    = PH_LENGTH;
                end
              end
            end
          end
        end
        default: begin
          // Idle: drop the item
        end
      endcase
    end
  end

  // Parser state and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q   <= LIMIT_RESET;
      phase_q <= PH_IDLE;
      lr_q    <= '0;
      idx_q   <= '0;
      oc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      lr_q    <= lr_d;
      idx_q   <= idx_d;
      oc_q    <= oc_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dwnt_queue.sv @@
// ----------------------------------------------------------------------------
// DNS name to text: command queue
// Small first-in first-out buffer that decouples the front end from the
// character generator.
// ----------------------------------------------------------------------------
`default_nettype none

module dwnt_queue import dwnt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      head_cmd_o,
  output logic      valid_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign head_cmd_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dwnt_back.sv @@
// ----------------------------------------------------------------------------
// DNS name to text: character generator
// Expands each queued command into its result items, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dwnt_back import dwnt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               head_cmd_i,
  input  wire logic               head_valid_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              text_char_o,
  output logic [1:0]              status_o,
  output logic [LIMIT_W-1:0]      consumed_o,
  output logic                    last_o
);

  logic [2:0]         step_q, step_d;
  logic [2:0]         body_n, total;
  logic               tail_n, at_last, load;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         char_d, char_q;
  status_e            status_d, status_q;
  logic [LIMIT_W-1:0] cons_d, cons_q;
  logic               last_q;

  // Result count of the head command
  always_comb begin
    case (head_cmd_i.body)
      BODY_PLAIN: body_n = 3'd1;
      BODY_ESC:   body_n = 3'(ESC_CHARS);
      BODY_DONE:  body_n = 3'd1;
      default:    body_n = 3'd0;
    endcase
    tail_n  = head_cmd_i.tail != TAIL_NONE;
    total   = body_n + {2'd0, tail_n};
    at_last = step_q == (total - 3'd1);
  end

  // Select the result for the current step
  always_comb begin
    char_d   = 8'd0;
    status_d = ST_CHAR;
    cons_d   = '0;
    if (step_q < body_n) begin
      case (head_cmd_i.body)
        BODY_PLAIN: char_d = head_cmd_i.data;
        BODY_DONE: begin
          status_d = ST_DONE;
          cons_d   = head_cmd_i.consumed;
        end
        BODY_ESC: begin
          case (step_q[1:0])
            2'd0:    char_d = CH_LBRACE;
            2'd1:    char_d = hex_digit(head_cmd_i.data[7:4]);
            2'd2:    char_d = hex_digit(head_cmd_i.data[3:0]);
            default: char_d = CH_RBRACE;
          endcase
        end
        default: char_d = 8'd0;
      endcase
    end else begin
      case (head_cmd_i.tail)
        TAIL_DOT: char_d   = CH_DOT;
        TAIL_ERR: status_d = ST_ERROR;
        default:  char_d   = 8'd0;
      endcase
    end
  end

  // Step sequencing and output handshake
  assign load        = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && at_last;
  assign step_d      = load ? (at_last ? 3'd0 : step_q + 3'd1) : step_q;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q   <= char_d;
      status_q <= status_d;
      cons_q   <= cons_d;
      last_q   <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign status_o    = status_q;
  assign consumed_o  = cons_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/dwnt_checker.sv @@
// ----------------------------------------------------------------------------
// DNS name to text: port checker
// Watches the output stream of the top level for result ordering and field
// consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_wire_name_to_text_top_defines.svh"

module dwnt_checker import dwnt_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // Hold a stalled item
  `DWNT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled output item changed")

  // Only character, done or error status
  `DWNT_ASSERT_NOW(a_status_legal, m_axis_tvalid_o, m_axis_tuser_o == ST_CHAR || m_axis_tuser_o == ST_DONE || m_axis_tuser_o == ST_ERROR, "illegal status code")

  // Terminator and error items close the item's results and carry no character
  `DWNT_ASSERT_NOW(a_end_last, m_axis_tvalid_o && m_axis_tuser_o != ST_CHAR, m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0, "end item not last or has a character")

  // Only the terminator carries a byte count
  `DWNT_ASSERT_NOW(a_consumed_zero, m_axis_tvalid_o && m_axis_tuser_o != ST_DONE, m_axis_tdata_o[17:8] == 10'd0, "byte count on a non-terminator item")

endmodule

bind dns_wire_name_to_text_top dwnt_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

@@ test/dns_wire_name_to_text_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS name to text: top-level testbench
// Drives wire-format name bytes into the input stream and checks every output
// item against a cycle-free predictor of the parser. Covers directed corner
// cases, random names under several length limits, random sender bursts,
// receiver stalls and one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------

module dns_wire_name_to_text_top_test;
  import dwnt_pkg::*;

  localparam int CNT_W        = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  // One expected output item
  typedef struct {
    logic [7:0]         text_char;
    status_e            status;
    logic [LIMIT_W-1:0] consumed;
    logic               last;
  } text_result_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_PATTERN
  } ready_mode_e;

  // Parser predictor and queue of expected text items
  class name_text_scoreboard;
    logic [LIMIT_W-1:0] limit;
    phase_e             phase;
    logic [6:0]         label_rem;
    logic [CNT_W-1:0]   in_idx;
    logic [CNT_W-1:0]   out_cnt;
    text_result_t       pending[$];
    int                 error_count;

    function new();
      limit       = LIMIT_RESET;
      phase       = PH_IDLE;
      label_rem   = '0;
      in_idx      = '0;
      out_cnt     = '0;
      error_count = 0;
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, int by);
      int s;
      s = int'(v) + by;
      return (s > (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(s);
    endfunction

    function logic [7:0] nibble_char(logic [3:0] nib);
      return (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_LA + 8'(nib - 4'd10);
    endfunction

    function bit is_plain(logic [7:0] b);
      return b inside {[CH_ZERO:CH_NINE], [CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_DASH, CH_UNDER};
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function void emit(logic [7:0] ch, status_e st, logic [LIMIT_W-1:0] used);
      text_result_t r;
      r.text_char = ch;
      r.status    = st;
      r.consumed  = used;
      r.last      = 1'b0;
      pending.push_back(r);
    endfunction

    // Advance the parser by one accepted byte and queue what it produces
    function void note_item(logic [7:0] b, logic first);
      int base;
      bit fail;
      base = pending.size();
      fail = 1'b0;
      if (first) begin
        phase     = PH_LENGTH;
        in_idx    = '0;
        out_cnt   = '0;
        label_rem = '0;
      end else if (phase == PH_IDLE) begin
        return;
      end else if (phase == PH_LENGTH) begin
        in_idx = sat_add(in_idx, 1);
      end

      if (phase == PH_LENGTH) begin
        // Length byte: zero or top bit set ends the name
        if (b == 8'h00 || b[7]) begin
          if (out_cnt >= limit) fail = 1'b1;
          else emit(8'h00, ST_DONE, LIMIT_W'(in_idx));
          phase = PH_IDLE;
        end else begin
          label_rem = b[6:0];
          phase     = PH_LABEL;
        end
      end else if (in_idx >= limit || out_cnt >= limit) begin
        fail = 1'b1;
      end else begin
        in_idx = sat_add(in_idx, 1);
        if (is_plain(b)) begin
          emit(b, ST_CHAR, '0);
          out_cnt = sat_add(out_cnt, 1);
        end else if (int'(out_cnt) + ESC_MARGIN >= int'(limit)) begin
          fail = 1'b1;
        end else begin
          emit(CH_LBRACE, ST_CHAR, '0);
          emit(nibble_char(b[7:4]), ST_CHAR, '0);
          emit(nibble_char(b[3:0]), ST_CHAR, '0);
          emit(CH_RBRACE, ST_CHAR, '0);
          out_cnt = sat_add(out_cnt, ESC_CHARS);
        end
        // Close the label with a dot once its last byte is through
        if (!fail) begin
          label_rem = label_rem - 7'd1;
          if (label_rem == 7'd0) begin
            if (out_cnt >= limit) begin
              fail = 1'b1;
            end else begin
              emit(CH_DOT, ST_CHAR, '0);
              out_cnt = sat_add(out_cnt, 1);
              phase   = PH_LENGTH;
            end
          end
        end
      end

      if (fail) begin
        emit(8'h00, ST_ERROR, '0);
        phase = PH_IDLE;
      end
      if (pending.size() > base) pending[pending.size() - 1].last = 1'b1;
    endfunction

    // Compare one output item with the oldest expectation
    function void check_result(logic [7:0] ch, logic [1:0] st, logic [LIMIT_W-1:0] used,
                               logic last);
      text_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected item: text_char %02h status %0d", ch, st);
        error_count++;
        return;
      end
      e = pending.pop_front();
      if (ch !== e.text_char) begin
        $error("text_char: expected %02h, got %02h", e.text_char, ch);
        error_count++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        error_count++;
      end
      if (used !== e.consumed) begin
        $error("bytes_consumed: expected %0d, got %0d", e.consumed, used);
        error_count++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i     = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i  = '0;  // [7:0] name_byte
  logic               s_axis_tuser_i  = 1'b0;  // [0] start_of_name
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [23:0]        m_axis_tdata_o;  // [7:0] text_char, [17:8] bytes_consumed
  logic [1:0]         m_axis_tuser_o;  // [1:0] status
  logic               m_axis_tlast_o;

  name_text_scoreboard sb;
  ready_mode_e         ready_mode  = RDY_ALWAYS;
  logic [7:0]          ready_pat   = 8'b1011_0010;
  int                  hold_cycles = 0;
  bit                  gaps_on     = 1'b0;
  int                  burst_left  = 0;
  int unsigned         cycle_count = 0;

  dns_wire_name_to_text_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: check accepted items, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o[7:0], m_axis_tuser_o, m_axis_tdata_o[17:8],
                        m_axis_tlast_o);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (ready_mode)
          RDY_ALWAYS: m_axis_tready_i <= 1'b1;
          RDY_RANDOM: m_axis_tready_i <= 1'($urandom_range(0, 1));
          RDY_SPARSE: m_axis_tready_i <= ($urandom_range(0, 5) == 0);
          default: begin
            m_axis_tready_i <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[7:1]};
          end
        endcase
      end
    end
  end

  // Offer one byte, honoring the burst/gap pattern, and wait for acceptance
  task automatic send_item(input logic [7:0] b, input logic first);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_item(b, first);
  endtask

  // Drop valid and wait until every expected item has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
  endtask

  function automatic logic [7:0] plain_byte();
    case ($urandom_range(0, 4))
      0:       return CH_LA + 8'($urandom_range(0, 25));
      1:       return CH_UA + 8'($urandom_range(0, 25));
      2:       return CH_ZERO + 8'($urandom_range(0, 9));
      3:       return CH_DASH;
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] end_byte();
    return ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(128, 255));
  endfunction

  // Send one name: labels of random content, a terminator, sometimes noise
  task automatic send_name(input int min_lab, input int max_lab, input int esc_pct);
    int         n_labels;
    int         len;
    int         l;
    int         j;
    logic [7:0] b;
    bit         stop;
    stop = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      // empty name
      send_item(end_byte(), 1'b1);
    end else begin
      n_labels = $urandom_range(1, 4);
      for (l = 0; l < n_labels && !stop; l++) begin
        len = $urandom_range(min_lab, max_lab);
        send_item(8'(len), l == 0);
        for (j = 0; j < len && !stop; j++) begin
          if ($urandom_range(0, 99) < esc_pct) b = 8'($urandom);
          else b = plain_byte();
          send_item(b, 1'b0);
          // overflow ended the name; leave the rest unsent
          if (sb.is_idle()) stop = 1'b1;
          // abandon mid-label so the next start restarts the parser
          if (max_lab <= 16 && $urandom_range(0, 49) == 0) begin
            stop = 1'b1;
            return;
          end
        end
      end
      if (!stop) send_item(end_byte(), 1'b0);
    end
    // stray bytes while the parser is idle
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset limit, plain and escaped bytes, restarts, idle bytes
    ready_mode = RDY_ALWAYS;
    send_item(8'h41, 1'b0);
    send_item(8'd3, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h39, 1'b0);
    send_item(8'd2, 1'b0);
    send_item(CH_DASH, 1'b0);
    send_item(CH_UNDER, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h7F, 1'b1);
    send_item(8'h7A, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h05, 1'b0);

    // Directed: smallest limit and zero limit
    write_limit(10'd1);
    send_item(8'd1, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
    write_limit(10'd0);
    send_item(8'h00, 1'b1);
    send_item(8'd2, 1'b1);
    send_item(8'h62, 1'b0);

    // Largest limit: one long escape-heavy name, often running into overflow
    write_limit(10'd1023);
    ready_mode = RDY_RANDOM;
    gaps_on    = 1'b1;
    send_name(100, 127, 95);
    send_name(1, 12, 30);

    // Mid-range limit with a long receiver hold-off and a steady sender
    write_limit(10'($urandom_range(41, 1022)));
    gaps_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (4) send_name(1, 12, 40);

    // Small limits with a sparse receiver
    write_limit(10'($urandom_range(2, 40)));
    ready_mode = RDY_SPARSE;
    gaps_on    = 1'b1;
    repeat (6) send_name(1, 8, 50);

    write_limit(10'd1);
    ready_mode = RDY_PATTERN;
    repeat (3) send_name(1, 4, 50);

    // Back to the reset limit, receiver always ready
    write_limit(LIMIT_RESET);
    ready_mode = RDY_ALWAYS;
    repeat (3) send_name(1, 10, 25);

    wait_drained();
    if (sb.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
